/* rtl/core/salru_pkg.sv */
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the set-associative tag directory.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int ADDRESS_W  = 16;
  localparam int WAY_OUT_W  = 3;
  localparam int SET_OUT_W  = 4;
  localparam int TAG_OUT_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int OFFSET_W    = 4;
  localparam int SETBITS_W   = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS    = 2'd1;

  localparam logic [OFFSET_W-1:0]  OFFSET_BITS_RESET = 4'd4;
  localparam logic [SETBITS_W-1:0] SET_BITS_RESET    = 3'd0;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [SET_OUT_W-1:0] set_index;
    logic                 evicted;
    logic [TAG_OUT_W-1:0] evicted_tag;
  } result_t;

endpackage

/* rtl/core/salru_fifo.sv */
// ----------------------------------------------------------------------------
// salru_fifo
// Small synchronous FIFO with 2**PTR_W entries, push/full and pop/empty.
// ----------------------------------------------------------------------------
module salru_fifo #(
  parameter int WIDTH = 1,
  parameter int PTR_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 1 << PTR_W;
  localparam logic [PTR_W:0] DEPTH_C = (PTR_W + 1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/core/salru_front.sv */
// ----------------------------------------------------------------------------
// salru_front
// Configuration registers and address split into set index and tag.
// ----------------------------------------------------------------------------
module salru_front #(
  parameter int SET_BITS_MAX = 4,
  parameter int SET_W        = 4,
  parameter int TAG_W        = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [salru_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                push,
  input  logic [salru_pkg::ADDRESS_W-1:0]     address,
  output logic                                full,
  output logic                                req_push,
  output logic [SET_W-1:0]                    req_set,
  output logic [TAG_W-1:0]                    req_tag,
  input  logic                                req_full
);

  localparam logic [3:0] SB_MAX = 4'(SET_BITS_MAX);

  logic [salru_pkg::OFFSET_W-1:0]  offset_bits;
  logic [salru_pkg::SETBITS_W-1:0] set_bits;
  logic [3:0]                      sb;
  logic [4:0]                      tag_shift;
  logic [TAG_W-1:0]                addr_in;
  logic [TAG_W-1:0]                shifted;
  logic [SET_W-1:0]                set_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= salru_pkg::OFFSET_BITS_RESET;
      set_bits    <= salru_pkg::SET_BITS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        salru_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data[salru_pkg::OFFSET_W-1:0];
        salru_pkg::REG_SET_BITS:    set_bits    <= cfg_data[salru_pkg::SETBITS_W-1:0];
        default: ;
      endcase
    end
  end

  // bits at or above ADDR_BITS are dropped
  assign addr_in = address[TAG_W-1:0];

  always_comb begin
    sb = ({1'b0, set_bits} > SB_MAX) ? SB_MAX : {1'b0, set_bits};
    tag_shift = {1'b0, offset_bits} + {1'b0, sb};
    shifted = addr_in >> offset_bits;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (4'(i) < sb);
    end
  end

  assign req_set  = shifted[SET_W-1:0] & set_mask;
  assign req_tag  = addr_in >> tag_shift;
  assign req_push = push && !req_full;
  assign full     = req_full;

endmodule

/* rtl/core/salru_back.sv */
// ----------------------------------------------------------------------------
// salru_back
// Tag lookup, matrix LRU victim choice and set update, one request at a time.
// ----------------------------------------------------------------------------
module salru_back #(
  parameter int WAYS         = 8,
  parameter int SET_BITS_MAX = 4,
  parameter int SET_W        = 4,
  parameter int TAG_W        = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_empty,
  input  logic [SET_W-1:0]     req_set,
  input  logic [TAG_W-1:0]     req_tag,
  output logic                 req_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output salru_pkg::result_t   res
);

  localparam int WAY_W = $clog2(WAYS);
  localparam int NSETS = 1 << SET_BITS_MAX;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                    state;
  logic [SET_W-1:0]        cur_set;
  logic [TAG_W-1:0]        cur_tag;

  logic [WAYS*TAG_W-1:0]   tag_mem [NSETS];
  logic [WAYS*WAYS-1:0]    lru_mem [NSETS];
  logic [WAYS-1:0]         valid_bits [NSETS];

  logic [WAYS*TAG_W-1:0]   tag_rd;
  logic [WAYS*WAYS-1:0]    lru_rd;
  logic [WAYS*TAG_W-1:0]   tag_wr;
  logic [WAYS*WAYS-1:0]    lru_wr;
  logic [WAYS-1:0]         valid_row;
  logic [WAYS-1:0]         valid_wr;
  logic                    row_used;
  logic [WAYS-1:0]         match;
  logic [WAYS-1:0]         zero_row;
  logic                    hit;
  logic [WAY_W-1:0]        hit_way;
  logic [WAY_W-1:0]        victim;
  logic [WAY_W-1:0]        tgt;
  logic                    evicted;
  logic [TAG_W-1:0]        ev_tag;
  logic                    rd_en;
  logic                    wr_en;

  assign rd_en    = (state == ST_IDLE) && !req_empty && !res_full;
  assign wr_en    = (state == ST_EXEC);
  assign req_pop  = rd_en;
  assign res_push = wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (rd_en) state <= ST_EXEC;
        ST_EXEC: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_set <= req_set;
      cur_tag <= req_tag;
      tag_rd  <= tag_mem[req_set];
      lru_rd  <= lru_mem[req_set];
    end
    if (wr_en) begin
      tag_mem[cur_set] <= tag_wr;
      lru_mem[cur_set] <= lru_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSETS; s++) begin
        valid_bits[s] <= '0;
      end
    end else if (wr_en) begin
      valid_bits[cur_set] <= valid_wr;
    end
  end

  assign valid_row = valid_bits[cur_set];
  // a set with no valid way has not been touched since reset, so its matrix is read as zero
  assign row_used  = |valid_row;

  always_comb begin
    logic [WAYS-1:0] row;
    match    = '0;
    zero_row = '0;
    hit_way  = '0;
    victim   = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w]    = valid_row[w] && (tag_rd[w*TAG_W +: TAG_W] == cur_tag);
      row         = lru_rd[w*WAYS +: WAYS] & {WAYS{row_used}};
      zero_row[w] = (row == '0);
    end
    // lowest index wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (zero_row[w]) victim = WAY_W'(w);
    end
    hit = |match;
    tgt = hit ? hit_way : victim;
  end

  always_comb begin
    logic [WAYS-1:0] row;
    tag_wr   = tag_rd;
    valid_wr = valid_row;
    if (!hit) begin
      tag_wr[victim*TAG_W +: TAG_W] = cur_tag;
      valid_wr[victim] = 1'b1;
    end
    for (int r = 0; r < WAYS; r++) begin
      row = (WAY_W'(r) == tgt) ? {WAYS{1'b1}} : (lru_rd[r*WAYS +: WAYS] & {WAYS{row_used}});
      row[tgt] = 1'b0;
      lru_wr[r*WAYS +: WAYS] = row;
    end
    evicted = !hit && valid_row[victim];
    ev_tag  = evicted ? tag_rd[victim*TAG_W +: TAG_W] : '0;
  end

  always_comb begin
    logic [WAY_W+salru_pkg::WAY_OUT_W-1:0] way_ext;
    logic [SET_W+salru_pkg::SET_OUT_W-1:0] set_ext;
    logic [TAG_W+salru_pkg::TAG_OUT_W-1:0] tag_ext;
    way_ext = {{salru_pkg::WAY_OUT_W{1'b0}}, tgt};
    set_ext = {{salru_pkg::SET_OUT_W{1'b0}}, cur_set};
    tag_ext = {{salru_pkg::TAG_OUT_W{1'b0}}, ev_tag};
    res.hit         = hit;
    res.way         = way_ext[salru_pkg::WAY_OUT_W-1:0];
    res.set_index   = set_ext[salru_pkg::SET_OUT_W-1:0];
    res.evicted     = evicted;
    res.evicted_tag = tag_ext[salru_pkg::TAG_OUT_W-1:0];
  end

endmodule

/* rtl/core/set_assoc_cache_matrix_lru_unit.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_matrix_lru_unit
// Tag directory of a set-associative cache with matrix LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Addresses go in like a queue: drive address with push; the request is
//   taken on a clock edge with push high and full low.
//   Results come out like a queue: while empty is low the oldest result sits
//   on hit, way, set_index, evicted and evicted_tag; pop takes it. The user
//   must write offset_bits (index 0) and set_bits (index 1) through
//   cfg_write / cfg_index / cfg_data only while no request is in flight; the block does not enforce it.
// Flow:
//   A request is split into set and tag and queued; the lookup engine then
//   takes one request at a time: it reads the set's tag and LRU rows as it
//   pops the request, then compares, updates and writes back while pushing
//   the result into the result queue, and pops no new request before that
//   write-back of the set is done.
// Reset:
//   rst clears all valid bits, which also makes every LRU row read as zero,
//   and empties both queues; configuration returns to offset 4, no set bits.
// Stall:
//   A held result stalls the engine once the two-entry result queue fills,
//   and full rises once the two-entry input queue fills as well.
// ----------------------------------------------------------------------------
module set_assoc_cache_matrix_lru_unit #(
  parameter int ADDR_BITS    = 16,
  parameter int WAYS         = 8,
  parameter int SET_BITS_MAX = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [salru_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                push,
  input  logic [salru_pkg::ADDRESS_W-1:0]     address,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output logic                                hit,
  output logic [salru_pkg::WAY_OUT_W-1:0]     way,
  output logic [salru_pkg::SET_OUT_W-1:0]     set_index,
  output logic                                evicted,
  output logic [salru_pkg::TAG_OUT_W-1:0]     evicted_tag
);

  localparam int SET_W = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
  localparam int TAG_W = (ADDR_BITS < salru_pkg::ADDRESS_W) ? ADDR_BITS
                                                             : salru_pkg::ADDRESS_W;
  localparam int REQ_W = SET_W + TAG_W;
  localparam int RES_W = $bits(salru_pkg::result_t);

  logic               req_push;
  logic               req_full;
  logic               req_empty;
  logic               req_pop;
  logic [SET_W-1:0]   f_set;
  logic [TAG_W-1:0]   f_tag;
  logic [REQ_W-1:0]   q_req;
  logic               res_push;
  logic               res_full;
  salru_pkg::result_t res_in;
  salru_pkg::result_t res_out;

  salru_front #(
    .SET_BITS_MAX (SET_BITS_MAX),
    .SET_W        (SET_W),
    .TAG_W        (TAG_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .address   (address),
    .full      (full),
    .req_push  (req_push),
    .req_set   (f_set),
    .req_tag   (f_tag),
    .req_full  (req_full)
  );

  salru_fifo #(
    .WIDTH (REQ_W),
    .PTR_W (1)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (req_push),
    .wdata ({f_set, f_tag}),
    .full  (req_full),
    .pop   (req_pop),
    .rdata (q_req),
    .empty (req_empty)
  );

  salru_back #(
    .WAYS         (WAYS),
    .SET_BITS_MAX (SET_BITS_MAX),
    .SET_W        (SET_W),
    .TAG_W        (TAG_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_empty (req_empty),
    .req_set   (q_req[REQ_W-1:TAG_W]),
    .req_tag   (q_req[TAG_W-1:0]),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  salru_fifo #(
    .WIDTH (RES_W),
    .PTR_W (1)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign hit         = res_out.hit;
  assign way         = res_out.way;
  assign set_index   = res_out.set_index;
  assign evicted     = res_out.evicted;
  assign evicted_tag = res_out.evicted_tag;

endmodule

/* rtl/core/salru_checker.sv */
// ----------------------------------------------------------------------------
// salru_checker
// Port-level checks of the tag directory, bound to the top level.
// ----------------------------------------------------------------------------
module salru_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                push,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic                                hit,
  input logic [salru_pkg::WAY_OUT_W-1:0]     way,
  input logic [salru_pkg::SET_OUT_W-1:0]     set_index,
  input logic                                evicted,
  input logic [salru_pkg::TAG_OUT_W-1:0]     evicted_tag
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a hit never displaces a tag
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(hit && evicted))
    else $error("hit reported with eviction");

  // evicted tag reads zero when nothing was displaced
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !evicted) |-> (evicted_tag == '0))
    else $error("evicted tag nonzero without eviction");

  // a result never shows up on the result side without an earlier push
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (empty && !(push && !full)) |=> empty || $past(push, 2) || $past(push, 3)
      || !$past(empty, 2) || $past(rst, 2))
    else $error("result without a request");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(hit) && $stable(way)
      && $stable(set_index) && $stable(evicted) && $stable(evicted_tag))
    else $error("waiting result changed");

endmodule

bind set_assoc_cache_matrix_lru_unit salru_checker u_salru_checker (.*);
